// ----- rtl/core/least_load_server_picker_macros.svh -----
// Assertion macros used by the checker file of the least-load server picker.
`ifndef LEAST_LOAD_SERVER_PICKER_MACROS_SVH
`define LEAST_LOAD_SERVER_PICKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/llsp_pkg.sv -----
// Shared types and codes of the least-load server picker.
`timescale 1ns / 1ps

package llsp_pkg;

    localparam int ADDR_W        = 32;
    localparam int PORT_W        = 16;
    localparam int SERVER_LOAD_W = 16;

    typedef enum logic [1:0] {
        REQ_CLIENT   = 2'd0,
        REQ_REGISTER = 2'd1,
        REQ_JOIN     = 2'd2,
        REQ_LEAVE    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_ASSIGNED   = 3'd0,
        ST_NONE       = 3'd1,
        ST_REGISTERED = 3'd2,
        ST_FULL       = 3'd3,
        ST_UPDATED    = 3'd4,
        ST_NOMATCH    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_RESP = 2'd2
    } fsm_t;

    // Scan token control bits passed from cell to cell.
    typedef struct packed {
        logic valid;
        logic found;
    } tok_ctl_t;

    // Write strobes broadcast from the sequencer to all cells.
    typedef struct packed {
        logic entry_we;
        logic load_we;
    } wr_ctl_t;

endpackage

// ----- rtl/core/llsp_cell.sv -----
// One table cell: holds a server entry and forwards the scan token one hop.
`timescale 1ns / 1ps

module llsp_cell #(
    parameter int LOAD_WIDTH = 16,
    parameter int IDX_W      = 4,
    parameter int CELL_IDX   = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_use,
    input  logic                         mode_min,
    input  logic [llsp_pkg::ADDR_W-1:0]  key_addr,
    input  logic [llsp_pkg::PORT_W-1:0]  key_port,
    input  llsp_pkg::wr_ctl_t            wr_ctl,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [llsp_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [llsp_pkg::PORT_W-1:0]  wr_port,
    input  logic [LOAD_WIDTH-1:0]        wr_load,
    input  llsp_pkg::tok_ctl_t           tok_in,
    input  logic [IDX_W-1:0]             idx_in,
    input  logic [LOAD_WIDTH-1:0]        load_in,
    input  logic [llsp_pkg::ADDR_W-1:0]  addr_in,
    input  logic [llsp_pkg::PORT_W-1:0]  port_in,
    output llsp_pkg::tok_ctl_t           tok_out,
    output logic [IDX_W-1:0]             idx_out,
    output logic [LOAD_WIDTH-1:0]        load_out,
    output logic [llsp_pkg::ADDR_W-1:0]  addr_out,
    output logic [llsp_pkg::PORT_W-1:0]  port_out
);

    logic [llsp_pkg::ADDR_W-1:0] addr_reg;
    logic [llsp_pkg::PORT_W-1:0] port_reg;
    logic [LOAD_WIDTH-1:0]       load_reg;

    llsp_pkg::tok_ctl_t          tok_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [LOAD_WIDTH-1:0]       tload_reg;
    logic [llsp_pkg::ADDR_W-1:0] taddr_reg;
    logic [llsp_pkg::PORT_W-1:0] tport_reg;

    logic sel;
    logic take;
    logic take_min;
    logic take_match;

    assign sel        = (wr_idx == IDX_W'(CELL_IDX));
    // ties go to the newer entry: scan runs oldest to newest, equal replaces
    assign take_min   = in_use && (!tok_in.found || (load_reg <= load_in));
    assign take_match = in_use && (addr_reg == key_addr) && (port_reg == key_port);
    assign take       = mode_min ? take_min : take_match;

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_ctl.entry_we && sel)
        begin
            addr_reg <= wr_addr;
            port_reg <= wr_port;
        end
        if (wr_ctl.load_we && sel)
        begin
            load_reg <= wr_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg.valid <= tok_in.valid;
            tok_reg.found <= tok_in.found | take;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= take ? IDX_W'(CELL_IDX) : idx_in;
        tload_reg <= take ? load_reg : load_in;
        taddr_reg <= take ? addr_reg : addr_in;
        tport_reg <= take ? port_reg : port_in;
    end

    assign tok_out  = tok_reg;
    assign idx_out  = idx_reg;
    assign load_out = tload_reg;
    assign addr_out = taddr_reg;
    assign port_out = tport_reg;

endmodule

// ----- rtl/core/least_load_server_picker.sv -----
// Top level of the least-load server picker: request sequencer and cell chain.
`timescale 1ns / 1ps

// Channel   Direction  Fields (low bit up)
// s_*       in         tuser: req_type[1:0]; tdata: peer_addr[31:0], peer_port[47:32]
// m_*       out        tuser: status[2:0];   tdata: server_addr[31:0], server_port[47:32],
//                                                   server_load[63:48]
//
// Register requests and client requests on an empty table skip the scan and go to the response state.
// Client, join and leave requests send a token down the chain of MAX_SERVERS cells,
// one cell per cycle; the response is formed once the token leaves the tail cell.
// One request is in work at a time; s_tready is high only while the sequencer idles.
// The result register holds a finished response while m_tready is low, and the next
// request is still taken; that request's response waits until the register drains.
// Reset empties the table at once (entry count to zero); no clearing pass is needed.

module least_load_server_picker #(
    parameter int MAX_SERVERS = 16,
    parameter int LOAD_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // peer_addr[31:0], peer_port[47:32]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // server_addr[31:0], server_port[47:32], server_load[63:48]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);
    localparam int AW    = llsp_pkg::ADDR_W;
    localparam int PW    = llsp_pkg::PORT_W;
    localparam int RW    = llsp_pkg::SERVER_LOAD_W;
    localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = {LOAD_WIDTH{1'b1}};

    // sequencer state
    llsp_pkg::fsm_t      state_reg, state_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic                launch_reg, launch_next;
    llsp_pkg::req_t      req_reg, req_next;
    logic [AW-1:0]       key_addr_reg, key_addr_next;
    logic [PW-1:0]       key_port_reg, key_port_next;

    // pending response
    llsp_pkg::status_t   res_status_reg, res_status_next;
    logic [AW-1:0]       res_addr_reg, res_addr_next;
    logic [PW-1:0]       res_port_reg, res_port_next;
    logic [RW-1:0]       res_load_reg, res_load_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    llsp_pkg::status_t   out_status_reg, out_status_next;
    logic [AW-1:0]       out_addr_reg, out_addr_next;
    logic [PW-1:0]       out_port_reg, out_port_next;
    logic [RW-1:0]       out_load_reg, out_load_next;

    // cell chain wiring, index 0 is the head, MAX_SERVERS the tail
    llsp_pkg::tok_ctl_t  tok   [MAX_SERVERS+1];
    logic [IDX_W-1:0]    tidx  [MAX_SERVERS+1];
    logic [LOAD_WIDTH-1:0] tload [MAX_SERVERS+1];
    logic [AW-1:0]       taddr [MAX_SERVERS+1];
    logic [PW-1:0]       tport [MAX_SERVERS+1];
    logic [MAX_SERVERS-1:0] in_use;

    llsp_pkg::wr_ctl_t   wr_ctl;
    logic [IDX_W-1:0]    wr_idx;
    logic [LOAD_WIDTH-1:0] wr_load;
    logic                mode_min;

    logic                accept;
    logic                out_free;
    logic [LOAD_WIDTH-1:0] tail_load;
    logic [LOAD_WIDTH-1:0] new_load;
    logic [RW-1:0]       new_load_rep;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign mode_min  = (req_reg == llsp_pkg::REQ_CLIENT);
    assign tail_load = tload[MAX_SERVERS];

    // saturating update of the chosen entry's count
    always_comb
    begin
        if (req_reg == llsp_pkg::REQ_LEAVE)
        begin
            new_load = (tail_load == '0) ? tail_load : tail_load - 1'b1;
        end
        else
        begin
            new_load = (tail_load == LOAD_MAX) ? tail_load : tail_load + 1'b1;
        end
    end

    // reported count saturates at the width of the result field
    generate
        if (LOAD_WIDTH > RW)
        begin : g_rep_sat
            assign new_load_rep = (|new_load[LOAD_WIDTH-1:RW]) ? {RW{1'b1}}
                                                               : new_load[RW-1:0];
        end
        else
        begin : g_rep_ext
            assign new_load_rep = RW'(new_load);
        end
    endgenerate

    // head of the chain: fresh token, nothing found yet
    assign tok[0].valid = launch_reg;
    assign tok[0].found = 1'b0;
    assign tidx[0]      = '0;
    assign tload[0]     = '0;
    assign taddr[0]     = '0;
    assign tport[0]     = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SERVERS; g++)
        begin : g_cell
            assign in_use[g] = (used_reg > CNT_W'(g));

            llsp_cell #(
                .LOAD_WIDTH (LOAD_WIDTH),
                .IDX_W      (IDX_W),
                .CELL_IDX   (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_use   (in_use[g]),
                .mode_min (mode_min),
                .key_addr (key_addr_reg),
                .key_port (key_port_reg),
                .wr_ctl   (wr_ctl),
                .wr_idx   (wr_idx),
                .wr_addr  (s_tdata[AW-1:0]),
                .wr_port  (s_tdata[AW+PW-1:AW]),
                .wr_load  (wr_load),
                .tok_in   (tok[g]),
                .idx_in   (tidx[g]),
                .load_in  (tload[g]),
                .addr_in  (taddr[g]),
                .port_in  (tport[g]),
                .tok_out  (tok[g+1]),
                .idx_out  (tidx[g+1]),
                .load_out (tload[g+1]),
                .addr_out (taddr[g+1]),
                .port_out (tport[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llsp_pkg::FSM_IDLE;
            used_reg      <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_addr_reg   <= key_addr_next;
        key_port_reg   <= key_port_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_port_reg   <= res_port_next;
        res_load_reg   <= res_load_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_port_reg   <= out_port_next;
        out_load_reg   <= out_load_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        launch_next     = 1'b0;
        req_next        = req_reg;
        key_addr_next   = key_addr_reg;
        key_port_next   = key_port_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_port_next   = res_port_reg;
        res_load_next   = res_load_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_port_next   = out_port_reg;
        out_load_next   = out_load_reg;
        wr_ctl          = '0;
        wr_idx          = tidx[MAX_SERVERS];
        wr_load         = new_load;
        s_tready        = 1'b0;

        unique case (state_reg)
            llsp_pkg::FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    req_next        = llsp_pkg::req_t'(s_tuser);
                    key_addr_next   = s_tdata[AW-1:0];
                    key_port_next   = s_tdata[AW+PW-1:AW];
                    res_addr_next   = '0;
                    res_port_next   = '0;
                    res_load_next   = '0;
                    state_next      = llsp_pkg::FSM_RESP;
                    unique case (llsp_pkg::req_t'(s_tuser))
                        llsp_pkg::REQ_CLIENT:
                        begin
                            if (used_reg == '0)
                            begin
                                res_status_next = llsp_pkg::ST_NONE;
                            end
                            else
                            begin
                                launch_next = 1'b1;
                                state_next  = llsp_pkg::FSM_SCAN;
                            end
                        end
                        llsp_pkg::REQ_REGISTER:
                        begin
                            if (used_reg >= CNT_W'(MAX_SERVERS))
                            begin
                                res_status_next = llsp_pkg::ST_FULL;
                            end
                            else
                            begin
                                // append at the fill mark with a zero count
                                wr_ctl.entry_we = 1'b1;
                                wr_ctl.load_we  = 1'b1;
                                wr_idx          = used_reg[IDX_W-1:0];
                                wr_load         = '0;
                                used_next       = used_reg + 1'b1;
                                res_status_next = llsp_pkg::ST_REGISTERED;
                            end
                        end
                        default:
                        begin
                            // join or leave: search for the newest match
                            launch_next = 1'b1;
                            state_next  = llsp_pkg::FSM_SCAN;
                        end
                    endcase
                end
            end

            llsp_pkg::FSM_SCAN:
            begin
                if (tok[MAX_SERVERS].valid)
                begin
                    state_next = llsp_pkg::FSM_RESP;
                    if (!tok[MAX_SERVERS].found)
                    begin
                        res_status_next = llsp_pkg::ST_NOMATCH;
                    end
                    else
                    begin
                        wr_ctl.load_we = 1'b1;
                        res_load_next  = new_load_rep;
                        if (mode_min)
                        begin
                            res_status_next = llsp_pkg::ST_ASSIGNED;
                            res_addr_next   = taddr[MAX_SERVERS];
                            res_port_next   = tport[MAX_SERVERS];
                        end
                        else
                        begin
                            res_status_next = llsp_pkg::ST_UPDATED;
                        end
                    end
                end
            end

            llsp_pkg::FSM_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_port_next   = res_port_reg;
                    out_load_next   = res_load_reg;
                    state_next      = llsp_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = llsp_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_load_reg, out_port_reg, out_addr_reg};

endmodule

// ----- rtl/core/llsp_checker.sv -----
// Port-level checks of the least-load server picker, bound to the top level.
`timescale 1ns / 1ps
`include "least_load_server_picker_macros.svh"

module llsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled response holds
    `LLSP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "response changed while stalled")

    // one request in work at a time
    `LLSP_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // only defined status codes leave the block
    `LLSP_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid, m_tuser <= 3'(llsp_pkg::ST_NOMATCH), "undefined status code")

    // address and port only accompany an assignment
    `LLSP_ASSERT_NOW(a_addr_zero, clk, rst_n, m_tvalid && (m_tuser != 3'(llsp_pkg::ST_ASSIGNED)), m_tdata[47:0] == 48'd0, "server fields set without assignment")

    // a count only accompanies an assignment or an update
    `LLSP_ASSERT_NOW(a_load_zero, clk, rst_n, m_tvalid && (m_tuser != 3'(llsp_pkg::ST_ASSIGNED)) && (m_tuser != 3'(llsp_pkg::ST_UPDATED)), m_tdata[63:48] == 16'd0, "count set on a status without one")

endmodule

bind least_load_server_picker llsp_checker u_llsp_checker (.*);

// ----- dv/least_load_server_picker_tb.sv -----
// Self-checking testbench of the least-load server picker: directed table, then random requests.
`timescale 1ns / 1ps

module least_load_server_picker_tb;

    localparam int NUM_SERVERS     = 16;
    // Narrow counts so that saturation at the top is reachable in a short run.
    localparam int LOAD_BITS       = 4;
    localparam logic [LOAD_BITS-1:0] LOAD_TOP = '1;
    localparam int NUM_PHASES      = 4;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int CYCLE_LIMIT     = 200000;
    // Longest request walks the whole cell chain; the wait after the last response leaves margin for that.
    localparam int DRAIN_CYCLES    = 2 * NUM_SERVERS + 16;
    localparam int REPORT_LIMIT    = 10;

    // One response as it leaves the master side.
    typedef struct packed {
        llsp_pkg::status_t                  st;
        logic [llsp_pkg::ADDR_W-1:0]        addr;
        logic [llsp_pkg::PORT_W-1:0]        port;
        logic [llsp_pkg::SERVER_LOAD_W-1:0] load;
    } reply_t;

    // One row of the directed table; typed rows carry a hand-written response.
    typedef struct {
        llsp_pkg::req_t              req;
        logic [llsp_pkg::ADDR_W-1:0] addr;
        logic [llsp_pkg::PORT_W-1:0] port;
        bit                          typed;
        reply_t                      want;
    } dir_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;                    // peer_addr[31:0], peer_port[47:32]
    logic [1:0]  s_tuser  = llsp_pkg::REQ_CLIENT;  // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // server_addr[31:0], server_port[47:32], server_load[63:48]
    logic [2:0]  m_tuser;            // status[2:0]

    // Shadow copy of the server table, kept by the predictor.
    logic [llsp_pkg::ADDR_W-1:0] tab_addr [NUM_SERVERS];
    logic [llsp_pkg::PORT_W-1:0] tab_port [NUM_SERVERS];
    logic [LOAD_BITS-1:0]        tab_load [NUM_SERVERS];
    int                          tab_used = 0;

    reply_t   pending_replies[$];
    dir_row_t dir_rows[$];

    int idle_pct        = 0;   // chance per cycle that the sender holds back
    int stall_pct       = 0;   // chance per cycle that the receiver stalls
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int sent_count      = 0;
    int dir_count       = 0;
    int replies_seen    = 0;
    int saturated_seen  = 0;
    int status_hits[6]  = '{default: 0};

    least_load_server_picker #(
        .MAX_SERVERS(NUM_SERVERS),
        .LOAD_WIDTH (LOAD_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Count as reported on server_load: saturated at 16 bits for wide counts.
    function automatic logic [llsp_pkg::SERVER_LOAD_W-1:0] load_view(
        logic [LOAD_BITS-1:0] cnt);
        return (64'(cnt) > 64'hFFFF) ? '1 : llsp_pkg::SERVER_LOAD_W'(cnt);
    endfunction

    // Applies one request to the shadow table and returns the response it must produce.
    function automatic reply_t predict_reply(llsp_pkg::req_t rq,
                                             logic [llsp_pkg::ADDR_W-1:0] a,
                                             logic [llsp_pkg::PORT_W-1:0] p);
        reply_t r;
        int     best;
        int     hit;
        int     i;
        r    = '{st: llsp_pkg::ST_NONE, addr: '0, port: '0, load: '0};
        best = -1;
        hit  = -1;
        case (rq)
            llsp_pkg::REQ_CLIENT:
            begin
                if (tab_used != 0)
                begin
                    // Newest first; only a strictly smaller count takes over, so ties
                    // stay with the most recently registered server.
                    best = tab_used - 1;
                    for (i = tab_used - 2; i >= 0; i--)
                        if (tab_load[i] < tab_load[best])
                            best = i;
                    if (tab_load[best] != LOAD_TOP)
                        tab_load[best]++;
                    r.st   = llsp_pkg::ST_ASSIGNED;
                    r.addr = tab_addr[best];
                    r.port = tab_port[best];
                    r.load = load_view(tab_load[best]);
                end
            end
            llsp_pkg::REQ_REGISTER:
            begin
                if (tab_used >= NUM_SERVERS)
                    r.st = llsp_pkg::ST_FULL;
                else
                begin
                    tab_addr[tab_used] = a;
                    tab_port[tab_used] = p;
                    tab_load[tab_used] = '0;
                    tab_used++;
                    r.st = llsp_pkg::ST_REGISTERED;
                end
            end
            default:
            begin
                // Join or leave: newest entry with matching address and port.
                for (i = tab_used - 1; i >= 0 && hit < 0; i--)
                    if (tab_addr[i] == a && tab_port[i] == p)
                        hit = i;
                if (hit < 0)
                    r.st = llsp_pkg::ST_NOMATCH;
                else
                begin
                    if (rq == llsp_pkg::REQ_JOIN && tab_load[hit] != LOAD_TOP)
                        tab_load[hit]++;
                    else if (rq == llsp_pkg::REQ_LEAVE && tab_load[hit] != '0)
                        tab_load[hit]--;
                    r.st   = llsp_pkg::ST_UPDATED;
                    r.load = load_view(tab_load[hit]);
                end
            end
        endcase
        return r;
    endfunction

    function automatic dir_row_t mk_row(llsp_pkg::req_t rq, logic [llsp_pkg::ADDR_W-1:0] a,
                                        logic [llsp_pkg::PORT_W-1:0] p, bit typed,
                                        llsp_pkg::status_t st,
                                        logic [llsp_pkg::SERVER_LOAD_W-1:0] ld);
        dir_row_t row;
        row.req   = rq;
        row.addr  = a;
        row.port  = p;
        row.typed = typed;
        row.want  = '{st: st, addr: '0, port: '0, load: ld};
        return row;
    endfunction

    task automatic report_mismatch(string what, reply_t want, reply_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected st=%0d addr=%h port=%h load=%0d, got st=%0d addr=%h port=%h load=%0d",
                     $time, what, want.st, want.addr, want.port, want.load,
                     got.st, got.addr, got.port, got.load);
    endtask

    // Drives one request; inputs change on the falling edge, acceptance is seen on the
    // rising edge. A typed response replaces the predicted one in the check queue, but the
    // predictor always runs so the shadow table stays in step.
    task automatic send_request(llsp_pkg::req_t rq, logic [llsp_pkg::ADDR_W-1:0] a,
                                logic [llsp_pkg::PORT_W-1:0] p, bit typed, reply_t want);
        reply_t pred;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {p, a};
        do @(posedge clk); while (!s_tready);
        pred = predict_reply(rq, a, p);
        pending_replies.push_back(typed ? want : pred);
        sent_count++;
    endtask

    // Random request. Join, leave and register requests mostly name a registered server,
    // sometimes a near miss (one bit off) or a random pair.
    task automatic random_request(int leave_pct);
        int                          roll;
        int                          pick;
        llsp_pkg::req_t              rq;
        logic [llsp_pkg::ADDR_W-1:0] a;
        logic [llsp_pkg::PORT_W-1:0] p;
        roll = $urandom_range(99);
        a    = $urandom;
        p    = llsp_pkg::PORT_W'($urandom_range(16'hFFFF));
        if (roll < 8)
            rq = llsp_pkg::REQ_REGISTER;
        else if (roll < 8 + leave_pct)
            rq = llsp_pkg::REQ_LEAVE;
        else if ($urandom_range(99) < 60)
            rq = llsp_pkg::REQ_CLIENT;
        else
            rq = llsp_pkg::REQ_JOIN;
        if (rq != llsp_pkg::REQ_CLIENT && tab_used > 0 && $urandom_range(99) < 85)
        begin
            pick = $urandom_range(tab_used - 1);
            a    = tab_addr[pick];
            p    = tab_port[pick];
            if ($urandom_range(9) == 0)
                a = a ^ (32'd1 << $urandom_range(31));
            else if ($urandom_range(9) == 0)
                p = p ^ (16'd1 << $urandom_range(15));
        end
        send_request(rq, a, p, 1'b0, '0);
    endtask

    // Receiver back-pressure, redrawn every falling edge.
    always @(negedge clk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // Response checker: compares each accepted response with the oldest expectation.
    always @(posedge clk)
    begin : resp_check
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.st   = llsp_pkg::status_t'(m_tuser);
            got.addr = m_tdata[31:0];
            got.port = m_tdata[47:32];
            got.load = m_tdata[63:48];
            replies_seen++;
            if (m_tuser <= 3'(llsp_pkg::ST_NOMATCH))
                status_hits[m_tuser]++;
            if (got.load == llsp_pkg::SERVER_LOAD_W'(LOAD_TOP))
                saturated_seen++;
            if (pending_replies.size() == 0)
                report_mismatch("response with no request outstanding", got, got);
            else
            begin
                want = pending_replies.pop_front();
                if (got.st !== want.st || got.addr !== want.addr ||
                    got.port !== want.port || got.load !== want.load)
                    report_mismatch("response mismatch", want, got);
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_replies.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int     k;
        int     ph;
        reply_t left;

        // Directed table. Typed rows: empty table, unknown servers, leave at zero count,
        // join on the newest duplicate, near misses, and register on a full table.
        dir_rows.push_back(mk_row(llsp_pkg::REQ_CLIENT, 32'h0A00_0001, 16'd80, 1'b1,
                                  llsp_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_JOIN, 32'h0A00_0001, 16'd80, 1'b1,
                                  llsp_pkg::ST_NOMATCH, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_LEAVE, 32'h0A00_0001, 16'd80, 1'b1,
                                  llsp_pkg::ST_NOMATCH, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_REGISTER, 32'h0000_0000, 16'h0000, 1'b1,
                                  llsp_pkg::ST_REGISTERED, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                  llsp_pkg::ST_REGISTERED, 16'd0));
        // Same pair again: appended as its own entry.
        dir_rows.push_back(mk_row(llsp_pkg::REQ_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                  llsp_pkg::ST_REGISTERED, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_LEAVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                  llsp_pkg::ST_UPDATED, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_JOIN, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                  llsp_pkg::ST_UPDATED, 16'd1));
        // Tie-breaking among the three entries is left to the predictor.
        dir_rows.push_back(mk_row(llsp_pkg::REQ_CLIENT, 32'h1234_5678, 16'h9ABC, 1'b0,
                                  llsp_pkg::ST_ASSIGNED, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_CLIENT, 32'h8765_4321, 16'h0001, 1'b0,
                                  llsp_pkg::ST_ASSIGNED, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_JOIN, 32'h0000_0000, 16'h0001, 1'b1,
                                  llsp_pkg::ST_NOMATCH, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_JOIN, 32'h0000_0001, 16'h0000, 1'b1,
                                  llsp_pkg::ST_NOMATCH, 16'd0));
        // Fill the rest of the table with random servers.
        for (k = 3; k < NUM_SERVERS; k++)
            dir_rows.push_back(mk_row(llsp_pkg::REQ_REGISTER, $urandom,
                                      llsp_pkg::PORT_W'($urandom_range(16'hFFFF)),
                                      1'b1, llsp_pkg::ST_REGISTERED, 16'd0));
        dir_rows.push_back(mk_row(llsp_pkg::REQ_REGISTER, 32'hC0A8_0101, 16'd8080, 1'b1,
                                  llsp_pkg::ST_FULL, 16'd0));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[n])
            send_request(dir_rows[n].req, dir_rows[n].addr, dir_rows[n].port,
                         dir_rows[n].typed, dir_rows[n].want);
        dir_count = sent_count;

        // Random phases: no idling, sender idle, receiver stalling, both. The first three
        // lean on increments to push counts into saturation, the last drains toward zero.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 15 : 0;
            stall_pct = (ph == 2) ? 70 : (ph == 3) ? 15 : 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                random_request((ph == 3) ? 60 : 10);
        end

        @(negedge clk);
        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (pending_replies.size() != 0)
        begin
            left = pending_replies.pop_front();
            report_mismatch("response never arrived", left, '0);
        end

        $display("%0d requests (%0d directed, %0d random over %0d idle/stall mixes), %0d responses, %0d at top count",
                 sent_count, dir_count, sent_count - dir_count, NUM_PHASES, replies_seen,
                 saturated_seen);
        $display("assigned %0d, none %0d, registered %0d, full %0d, updated %0d, no match %0d, mismatches %0d",
                 status_hits[llsp_pkg::ST_ASSIGNED], status_hits[llsp_pkg::ST_NONE],
                 status_hits[llsp_pkg::ST_REGISTERED], status_hits[llsp_pkg::ST_FULL],
                 status_hits[llsp_pkg::ST_UPDATED], status_hits[llsp_pkg::ST_NOMATCH],
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/llsp_pkg.sv
rtl/core/llsp_cell.sv
rtl/core/least_load_server_picker.sv
rtl/core/llsp_checker.sv
dv/least_load_server_picker_tb.sv
